// ===== src/dgr_pkg.sv =====
// Package with the item types, control structs and constants of the data generator register block.
package dgr_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned TYPE_W  = 8;
    localparam int unsigned SEQ_W   = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned EN_W    = 8;
    localparam int unsigned STEP_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] ADDR_COUNT  = 64'h0000_0000_0000_1001;
    localparam logic [WORD_W-1:0] ADDR_RATE   = 64'h0000_0000_0000_1002;
    localparam logic [WORD_W-1:0] ENABLE_ADDR = 64'd4099;
    localparam logic [WORD_W-1:0] RATE_RESET  = 64'h0000_0000_0001_0000;
    localparam logic [WORD_W-1:0] COUNT_ENDLESS = {WORD_W{1'b1}};

    localparam logic [TYPE_W-1:0] PKT_READ  = 8'd0;
    localparam logic [TYPE_W-1:0] PKT_WRITE = 8'd1;
    localparam logic [LEN_W-1:0]  READ_LEN      = 11'd10;
    localparam logic [LEN_W-1:0]  WRITE_MIN_LEN = 11'd18;
    localparam logic [2:0]        WRITE_LEN_MOD = 3'd2;

    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MIDDLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LAST   = 2'd3;

    localparam logic [SEQ_W-1:0]  SEQ_READ_INC  = 8'd2;
    localparam logic [SEQ_W-1:0]  SEQ_BURST_INC = 8'd1;

    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(WORD_W - 1);

    typedef struct packed {
        logic              func;
        logic [TYPE_W-1:0] pkt_type;
        logic [LEN_W-1:0]  pkt_len;
        logic [WORD_W-1:0] reg_addr;
        logic [WORD_W-1:0] write_word;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] resp_kind;
        logic [SEQ_W-1:0]  seq_id;
        logic [WORD_W-1:0] payload;
        logic              to_stream;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic div_step;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic has_result;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ===== src/dgr_in_if.sv =====
// Input channel interface carrying request packets and idle ticks.
interface dgr_in_if;
    logic              valid;
    logic              ready;
    dgr_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== src/dgr_out_if.sv =====
// Output channel interface carrying response and burst packets.
interface dgr_out_if;
    logic               valid;
    logic               ready;
    dgr_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== src/dgr_ctrl.sv =====
// Controller state machine that sequences accept, remainder iterations and commit.
module dgr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dgr_pkg::t_ctrl_sts  i_sts,
    output dgr_pkg::t_ctrl_cmd  o_cmd
);
    import dgr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No item is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // Hold here while a result waits for a full output register.
                if (!i_sts.has_result || i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dgr_datapath.sv =====
// Datapath with the generator registers, bit-serial remainder unit and output register.
module dgr_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dgr_pkg::t_in_item  i_item,
    input  dgr_pkg::t_ctrl_cmd i_cmd,
    output dgr_pkg::t_ctrl_sts o_sts,
    dgr_out_if.source          o_out
);
    import dgr_pkg::*;

    t_in_item          r_item;
    logic [WORD_W-1:0] r_gen_count, n_gen_count;
    logic [WORD_W-1:0] r_gen_rate, n_gen_rate;
    logic [EN_W-1:0]   r_gen_enable, n_gen_enable;
    logic              r_was_enabled, n_was_enabled;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [WORD_W-1:0] r_tick, n_tick;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvd;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   rem_diff;
    logic              is_read, is_write, fire;
    logic [WORD_W-1:0] read_data;
    t_out_item         res_item;
    logic              has_result;
    logic              out_free;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    assign rem_shift = {r_rem, r_dvd[WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_gen_rate};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dvd  <= r_tick;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_diff[WORD_W] ? rem_shift[WORD_W-1:0] : rem_diff[WORD_W-1:0];
            r_dvd  <= {r_dvd[WORD_W-2:0], 1'b0};
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign is_read  = r_item.func && (r_item.pkt_type == PKT_READ)
                      && (r_item.pkt_len == READ_LEN);
    assign is_write = r_item.func && (r_item.pkt_type == PKT_WRITE)
                      && (r_item.pkt_len >= WRITE_MIN_LEN)
                      && (r_item.pkt_len[2:0] == WRITE_LEN_MOD);

    assign o_sts.need_div = !r_item.func && (r_gen_enable != '0)
                            && (r_gen_rate != '0) && (r_gen_count != '0);
    assign o_sts.div_last = (r_step == DIV_LAST);
    assign fire           = o_sts.need_div && (r_rem == '0);

    always_comb begin
        priority if (r_item.reg_addr == ADDR_COUNT) begin
            read_data = r_gen_count;
        end else if (r_item.reg_addr == ADDR_RATE) begin
            read_data = r_gen_rate;
        end else if (r_item.reg_addr == ENABLE_ADDR) begin
            read_data = {{(WORD_W-EN_W){1'b0}}, r_gen_enable};
        end else begin
            read_data = '0;
        end
    end

    always_comb begin
        has_result         = 1'b0;
        res_item.resp_kind = KIND_READ;
        res_item.seq_id    = r_seq;
        res_item.payload   = r_tick;
        res_item.to_stream = 1'b1;
        n_gen_count        = r_gen_count;
        n_gen_rate         = r_gen_rate;
        n_gen_enable       = r_gen_enable;
        n_was_enabled      = r_was_enabled;
        n_seq              = r_seq;
        n_tick             = r_tick;
        if (r_item.func) begin
            if (is_read) begin
                has_result         = 1'b1;
                res_item.payload   = read_data;
                res_item.to_stream = 1'b0;
                n_seq              = r_seq + SEQ_READ_INC;
            end else if (is_write) begin
                priority if (r_item.reg_addr == ADDR_COUNT) begin
                    n_gen_count = r_item.write_word;
                    n_tick      = '0;
                end else if (r_item.reg_addr == ADDR_RATE) begin
                    n_gen_rate = r_item.write_word;
                end else if (r_item.reg_addr == ENABLE_ADDR) begin
                    n_gen_enable = r_item.write_word[EN_W-1:0];
                end else begin
                    n_gen_enable = r_gen_enable;
                end
            end
        end else begin
            if (r_gen_enable != '0) begin
                if (fire) begin
                    has_result         = 1'b1;
                    res_item.resp_kind = r_was_enabled ? KIND_MIDDLE : KIND_FIRST;
                    n_seq              = r_seq + SEQ_BURST_INC;
                    if (r_gen_count != COUNT_ENDLESS) begin
                        n_gen_count = r_gen_count - WORD_W'(1);
                    end
                end
                n_was_enabled = 1'b1;
            end else if (r_was_enabled) begin
                has_result         = 1'b1;
                res_item.resp_kind = KIND_LAST;
                n_seq              = r_seq + SEQ_BURST_INC;
                n_was_enabled      = 1'b0;
            end
            n_tick = r_tick + WORD_W'(1);
        end
    end

    assign out_free         = !r_out_valid || o_out.ready;
    assign o_sts.has_result = has_result;
    assign o_sts.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_count   <= '0;
            r_gen_rate    <= RATE_RESET;
            r_gen_enable  <= '0;
            r_was_enabled <= 1'b0;
            r_seq         <= '0;
            r_tick        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_gen_count   <= n_gen_count;
                r_gen_rate    <= n_gen_rate;
                r_gen_enable  <= n_gen_enable;
                r_was_enabled <= n_was_enabled;
                r_seq         <= n_seq;
                r_tick        <= n_tick;
            end
            if (i_cmd.commit && has_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && has_result) begin
            r_out_item <= res_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

endmodule

// ===== src/data_generator_register_block.sv =====
// Top level of the data generator register block: controller plus datapath.
//
// The block takes items on i_in: each item is either a received request
// packet (func set) or one idle tick (func clear). A valid read packet gives
// one response item on o_out carrying the addressed register; a valid write
// packet updates the count, rate or enable register and gives no item.
// On idle ticks while enabled, a burst item carrying the tick count is sent
// whenever the tick count is a multiple of the rate and the count is
// nonzero; the first tick after the enable drops sends one last-in-burst item.
// Each item is latched on acceptance, checked and then committed; a tick
// that checks the rate first runs through the bit-serial remainder unit,
// which retires one dividend bit per cycle over 64 bits. One item is
// processed at a time: the next item is taken only after the commit.
// Results sit in an output register, so the next item is accepted while a
// result waits; if a new result is ready while that register is still full,
// the block holds at commit until the receiver takes the waiting item.
// Reset (synchronous, active low) holds the input ready low, clears count,
// enable, sequence id and tick count, and sets the rate to 65536.
module data_generator_register_block (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dgr_in_if.sink     i_in,
    dgr_out_if.source  o_out
);
    import dgr_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // The controller owns the input handshake; the datapath owns the register and output state.
    dgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath captures the item on accept and drives the output channel.
    dgr_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in.item),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule
